// ----- rtl/bccm_pkg.sv -----
// shared types and constants for the bond chain component merge block
// no dependencies; used by bond_chain_component_merge_top
package bccm_pkg;

    localparam int ATOM_W        = 10;
    localparam int CNT_W         = 11;
    localparam int MAX_ATOMS_DEF = 1024;
    localparam logic [CNT_W-1:0] ATOM_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BOND  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_SPLICE,
        ST_OUT
    } state_e;

    // one link entry: tail mark plus next atom, or head atom for a tail
    typedef struct packed {
        logic              tail;
        logic [ATOM_W-1:0] atom;
    } link_t;

    typedef struct packed {
        op_e               op;
        logic [ATOM_W-1:0] atom_a;
        logic [ATOM_W-1:0] atom_b;
    } in_t;

    typedef struct packed {
        logic              merged;
        logic              same_molecule;
        logic [ATOM_W-1:0] tail_atom;
        logic [CNT_W-1:0]  molecule_count;
        logic              entry_is_tail;
        logic [ATOM_W-1:0] entry_atom;
        logic              bad_index;
    } out_t;

endpackage

// ----- rtl/bccm_ram.sv -----
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies
module bccm_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bond_chain_component_merge_top.sv -----
// bond chain component merge: link memory walker and splicer, top level
// depends on bccm_pkg and bccm_ram
//
//  channel | ports                       | payload
//  --------+-----------------------------+-------------------------
//  input   | s_valid s_ready s_data      | bccm_pkg::in_t
//  result  | m_valid m_ready m_data      | bccm_pkg::out_t
//  config  | cfg_valid cfg_ready cfg_data| atom_count, 11 bits
//
// one transaction at a time; each link is read through the registered ram port
// bond: walk both chains to their tails, then splice them unless the tails match
// read: walk one chain; start: clear the link memory (one entry cleared per cycle)
// nop or bad index: straight to the result; after reset a clearing pass over MAX_ATOMS
// a result waiting on m_ready does not block accepting the next input transaction
module bond_chain_component_merge_top #(
    parameter int MAX_ATOMS = bccm_pkg::MAX_ATOMS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bccm_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bccm_pkg::out_t             m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bccm_pkg::CNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int SW = $clog2(MAX_ATOMS + 1);
    localparam int ATOM_W = bccm_pkg::ATOM_W;
    localparam int CNT_W = bccm_pkg::CNT_W;

    bccm_pkg::state_e state_reg, state_next;
    bccm_pkg::op_e    op_reg, op_next;

    logic [CNT_W-1:0]  atom_count_reg;
    logic [CNT_W-1:0]  mol_left_reg, mol_left_next;
    logic [ATOM_W-1:0] b_reg, b_next;
    logic [ATOM_W-1:0] cur_reg, cur_next;
    logic [ATOM_W-1:0] ta_reg, ta_next;
    logic [ATOM_W-1:0] head_a_reg, head_a_next;
    logic [ATOM_W-1:0] head_b_reg, head_b_next;
    logic [SW-1:0]     steps_reg, steps_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              start_rep_reg, start_rep_next;
    logic              m_valid_reg, m_valid_next;
    bccm_pkg::out_t    res_reg, res_next;
    bccm_pkg::out_t    m_data_reg, m_data_next;

    logic [CNT_W-1:0]     eff_cnt;
    logic                 s_fire, out_free, a_bad, b_bad, walk_go, clr_last;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    bccm_pkg::link_t      ram_wlink, rd_link;
    logic [$bits(bccm_pkg::link_t)-1:0] ram_rdata;

    bccm_ram #(
        .WIDTH ($bits(bccm_pkg::link_t)),
        .DEPTH (MAX_ATOMS)
    ) u_links (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wlink),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_link = ram_rdata;

    // atom_count clamped to the link memory depth
    always_comb begin
        if (32'(atom_count_reg) > MAX_ATOMS) begin
            eff_cnt = CNT_W'(MAX_ATOMS);
        end else begin
            eff_cnt = atom_count_reg;
        end
    end

    assign s_ready   = (state_reg == bccm_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign a_bad     = ({1'b0, s_data.atom_a} >= eff_cnt);
    assign b_bad     = ({1'b0, s_data.atom_b} >= eff_cnt);
    assign walk_go   = !rd_link.tail && (steps_reg != SW'(MAX_ATOMS));
    assign clr_last  = (clr_reg == AW'(MAX_ATOMS - 1));
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bccm_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = start_rep_reg ? bccm_pkg::ST_OUT : bccm_pkg::ST_IDLE;
                end
            end
            bccm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.op)
                        bccm_pkg::OP_START: state_next = bccm_pkg::ST_CLEAR;
                        bccm_pkg::OP_BOND: begin
                            state_next = (a_bad || b_bad) ? bccm_pkg::ST_OUT
                                                          : bccm_pkg::ST_WALK_A;
                        end
                        bccm_pkg::OP_READ: begin
                            state_next = a_bad ? bccm_pkg::ST_OUT : bccm_pkg::ST_WALK_A;
                        end
                        bccm_pkg::OP_NOP: state_next = bccm_pkg::ST_OUT;
                    endcase
                end
            end
            bccm_pkg::ST_WALK_A: begin
                if (!walk_go) begin
                    state_next = (op_reg == bccm_pkg::OP_READ) ? bccm_pkg::ST_OUT
                                                               : bccm_pkg::ST_WALK_B;
                end
            end
            bccm_pkg::ST_WALK_B: begin
                if (!walk_go) begin
                    state_next = (cur_reg == ta_reg) ? bccm_pkg::ST_OUT
                                                     : bccm_pkg::ST_SPLICE;
                end
            end
            bccm_pkg::ST_SPLICE: state_next = bccm_pkg::ST_OUT;
            bccm_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = bccm_pkg::ST_IDLE;
                end
            end
            default: state_next = bccm_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory port and outputs
    always_comb begin
        op_next        = op_reg;
        mol_left_next  = mol_left_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        ta_next        = ta_reg;
        head_a_next    = head_a_reg;
        head_b_next    = head_b_reg;
        steps_next     = steps_reg;
        clr_next       = clr_reg;
        start_rep_next = start_rep_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wlink      = '0;
        ram_raddr      = AW'(cur_reg);

        unique case (state_reg)
            bccm_pkg::ST_CLEAR: begin
                ram_we         = 1'b1;
                ram_waddr      = clr_reg;
                ram_wlink.tail = 1'b1;
                ram_wlink.atom = ATOM_W'(clr_reg);
                clr_next       = clr_reg + AW'(1);
                if (clr_last) begin
                    mol_left_next = eff_cnt;
                end
            end
            bccm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    op_next    = s_data.op;
                    b_next     = s_data.atom_b;
                    cur_next   = s_data.atom_a;
                    steps_next = '0;
                    res_next   = '0;
                    ram_raddr  = AW'(s_data.atom_a);
                    unique case (s_data.op)
                        bccm_pkg::OP_START: begin
                            clr_next           = '0;
                            start_rep_next     = 1'b1;
                            res_next.tail_atom = a_bad ? '0 : s_data.atom_a;
                        end
                        bccm_pkg::OP_BOND: res_next.bad_index = a_bad || b_bad;
                        bccm_pkg::OP_READ: res_next.bad_index = a_bad;
                        bccm_pkg::OP_NOP: ;
                    endcase
                end
            end
            bccm_pkg::ST_WALK_A: begin
                // the first entry read is the one a read reports
                if (steps_reg == '0 && op_reg == bccm_pkg::OP_READ) begin
                    res_next.entry_is_tail = rd_link.tail;
                    res_next.entry_atom    = rd_link.atom;
                end
                if (walk_go) begin
                    cur_next   = rd_link.atom;
                    steps_next = steps_reg + SW'(1);
                    ram_raddr  = AW'(rd_link.atom);
                end else if (op_reg == bccm_pkg::OP_READ) begin
                    res_next.tail_atom = cur_reg;
                end else begin
                    ta_next     = cur_reg;
                    head_a_next = rd_link.atom;
                    cur_next    = b_reg;
                    steps_next  = '0;
                    ram_raddr   = AW'(b_reg);
                end
            end
            bccm_pkg::ST_WALK_B: begin
                if (walk_go) begin
                    cur_next   = rd_link.atom;
                    steps_next = steps_reg + SW'(1);
                    ram_raddr  = AW'(rd_link.atom);
                end else if (cur_reg == ta_reg) begin
                    res_next.same_molecule = 1'b1;
                    res_next.tail_atom     = ta_reg;
                end else begin
                    // tail b becomes the joint tail and takes head a
                    ram_we                = 1'b1;
                    ram_waddr             = AW'(cur_reg);
                    ram_wlink.tail        = 1'b1;
                    ram_wlink.atom        = head_a_reg;
                    head_b_next           = rd_link.atom;
                    res_next.merged       = 1'b1;
                    res_next.tail_atom    = cur_reg;
                end
            end
            bccm_pkg::ST_SPLICE: begin
                // old tail a now points at head b
                ram_we         = 1'b1;
                ram_waddr      = AW'(ta_reg);
                ram_wlink.tail = 1'b0;
                ram_wlink.atom = head_b_reg;
                if (mol_left_reg != '0) begin
                    mol_left_next = mol_left_reg - CNT_W'(1);
                end
            end
            bccm_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next                = res_reg;
                    m_data_next.molecule_count = mol_left_reg;
                    start_rep_next             = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bccm_pkg::ST_CLEAR;
            atom_count_reg <= bccm_pkg::ATOM_COUNT_RST;
            mol_left_reg   <= '0;
            clr_reg        <= '0;
            start_rep_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            steps_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            mol_left_reg  <= mol_left_next;
            clr_reg       <= clr_next;
            start_rep_reg <= start_rep_next;
            m_valid_reg   <= m_valid_next;
            steps_reg     <= steps_next;
            if (cfg_valid && cfg_ready) begin
                atom_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        ta_reg     <= ta_next;
        head_a_reg <= head_a_next;
        head_b_reg <= head_b_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // merged and same molecule never reported together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.merged && m_data_reg.same_molecule))
        else $error("merged and same_molecule both set");

    // a bad index leaves no bond or entry report
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.bad_index) |->
            (!m_data_reg.merged && !m_data_reg.same_molecule &&
             !m_data_reg.entry_is_tail && m_data_reg.entry_atom == '0))
        else $error("bad index result carries data");

    // a splice never raises the molecule count
    a_splice_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bccm_pkg::ST_SPLICE) |=> (mol_left_reg <= $past(mol_left_reg)))
        else $error("molecule count rose on splice");

    // walk length bounded by the memory depth
    a_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= SW'(MAX_ATOMS))
        else $error("chain walk overran");

    // an accepted transaction always leaves idle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("ready right after accept");

endmodule
